// ===== design/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and helpers for the strong liar check
// Field widths, datapath width and the modular add used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

   // Width of each input field on the request channel.
   localparam int FIELD_W = 32;

   // Datapath width. Inputs are cut down (or zero-extended) to this width.
   localparam int WIDTH = 32;

   // Counter width for bit positions and squaring counts.
   localparam int CNT_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [FIELD_W-1:0] field_type;

   // (p + q) mod n, for p, q < n.
   function automatic word_type mod_add(word_type p, word_type q, word_type n);
      logic [WIDTH:0] sum;
      logic [WIDTH:0] dif;
      sum = {1'b0, p} + {1'b0, q};
      dif = sum - {1'b0, n};
      return (sum >= {1'b0, n}) ? dif[WIDTH-1:0] : sum[WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/slc_if.sv =====
// ----------------------------------------------------------------------------
// slc_if: request and response channels
// Valid/ready channels carrying the test operands and the verdict word.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_req_if;
   logic                valid;
   logic                ready;
   slc_pkg::field_type  modulus;
   slc_pkg::field_type  base;

   modport source (output valid, output modulus, output base, input ready);
   modport sink   (input valid, input modulus, input base, output ready);
endinterface

interface slc_rsp_if;
   logic valid;
   logic ready;
   logic is_liar;
   logic input_error;

   modport source (output valid, output is_liar, output input_error, input ready);
   modport sink   (input valid, input is_liar, input input_error, output ready);
endinterface

`default_nettype wire

// ===== design/strong_liar_check_core.sv =====
// ----------------------------------------------------------------------------
// strong_liar_check_core: one strong probable prime round per request word
// Bit-serial modular multiply on a single shared mod-add unit.
// ----------------------------------------------------------------------------
// Takes a modulus n and a base a, writes n-1 = d*2^s and decides whether a
// is a strong liar for n (a^d = 1, or a^(d*2^k) = n-1 for some k < s). One
// request word is worked on at a time; req_chan.ready is high only while the
// sequencer sits idle. Bad operands (n even, n < 3, a < 2, a >= n) go from
// the range check to the verdict stage with input_error set and is_liar
// clear. Otherwise the one modular adder sets the pace: each modular product
// runs a doubling step per multiplier bit, an add step per set bit of the
// multiplier and a writeback step. A round strips the factors of two from
// n-1, then runs (bitlen(d) + popcount(d)) products for the exponentiation
// and up to s further squarings. The verdict sits in an output register, so
// a new request word is taken while the previous response word still waits
// for rsp_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module strong_liar_check_core (
   input  wire        clock,
   input  wire        reset,
   slc_req_if.sink    req_chan,
   slc_rsp_if.source  rsp_chan
);

   localparam int W  = slc_pkg::WIDTH;
   localparam int CW = slc_pkg::CNT_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHK   = 4'd1;  // operand range check
   localparam logic [3:0] ST_SPLIT = 4'd2;  // strip factors of two from n-1
   localparam logic [3:0] ST_POW   = 4'd3;  // square-and-multiply step
   localparam logic [3:0] ST_MDBL  = 4'd4;  // acc = 2*acc mod n
   localparam logic [3:0] ST_MADD  = 4'd5;  // acc = acc + x mod n
   localparam logic [3:0] ST_MWB   = 4'd6;  // product writeback
   localparam logic [3:0] ST_TEST  = 4'd7;  // x == 1 test
   localparam logic [3:0] ST_SQLP  = 4'd8;  // squaring loop
   localparam logic [3:0] ST_FIN   = 4'd9;  // hand verdict to output reg

   // product destinations
   localparam logic [1:0] DST_RES = 2'd0;
   localparam logic [1:0] DST_SQ  = 2'd1;
   localparam logic [1:0] DST_X   = 2'd2;

   logic [3:0]        state_ff, state_in;
   slc_pkg::word_type n_ff, n_in;
   slc_pkg::word_type nm1_ff, nm1_in;
   slc_pkg::word_type a_ff, a_in;
   slc_pkg::word_type e_ff, e_in;       // exponent, shifts right
   slc_pkg::word_type res_ff, res_in;   // running result, later x
   slc_pkg::word_type sq_ff, sq_in;     // running square
   slc_pkg::word_type mx_ff, mx_in;     // multiplicand
   slc_pkg::word_type my_ff, my_in;     // multiplier, shifts left
   slc_pkg::word_type acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [1:0]        dst_ff, dst_in;
   logic              liar_ff, liar_in;
   logic              err_ff, err_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_liar_ff, rsp_liar_in;
   logic              rsp_err_ff, rsp_err_in;

   // shared modular adder
   slc_pkg::word_type add_q;
   slc_pkg::word_type add_out;

   assign add_q   = (state_ff == ST_MADD) ? mx_ff : acc_ff;
   assign add_out = slc_pkg::mod_add(acc_ff, add_q, n_ff);

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.is_liar     = rsp_liar_ff;
   assign rsp_chan.input_error = rsp_err_ff;

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      nm1_in      = nm1_ff;
      a_in        = a_ff;
      e_in        = e_ff;
      res_in      = res_ff;
      sq_in       = sq_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      s_in        = s_ff;
      k_in        = k_ff;
      dst_in      = dst_ff;
      liar_in     = liar_ff;
      err_in      = err_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_liar_in = rsp_liar_ff;
      rsp_err_in  = rsp_err_ff;

      if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               n_in     = W'(req_chan.modulus);
               a_in     = W'(req_chan.base);
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            liar_in = 1'b0;
            nm1_in  = n_ff - W'(1);
            s_in    = '0;
            if (!n_ff[0] || n_ff < W'(3) || a_ff < W'(2) || a_ff >= n_ff) begin
               err_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               err_in   = 1'b0;
               e_in     = n_ff - W'(1);
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (!e_ff[0]) begin
               e_in = e_ff >> 1;
               s_in = s_ff + CW'(1);
            end else begin
               res_in   = W'(1);
               sq_in    = a_ff;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            acc_in = '0;
            cnt_in = CW'(W - 1);
            if (e_ff == '0) begin
               state_in = ST_TEST;
            end else if (e_ff[0]) begin
               mx_in    = res_ff;
               my_in    = sq_ff;
               dst_in   = DST_RES;
               state_in = ST_MDBL;
            end else begin
               mx_in    = sq_ff;
               my_in    = sq_ff;
               dst_in   = DST_SQ;
               state_in = ST_MDBL;
            end
         end
         ST_MDBL: begin
            acc_in = add_out;
            if (my_ff[W-1]) begin
               state_in = ST_MADD;
            end else begin
               my_in = my_ff << 1;
               if (cnt_ff == '0) begin
                  state_in = ST_MWB;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         ST_MADD: begin
            acc_in = add_out;
            my_in  = my_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_MWB;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_MDBL;
            end
         end
         ST_MWB: begin
            acc_in = '0;
            cnt_in = CW'(W - 1);
            unique case (dst_ff)
               DST_RES: begin
                  res_in   = acc_ff;
                  mx_in    = sq_ff;
                  my_in    = sq_ff;
                  dst_in   = DST_SQ;
                  state_in = ST_MDBL;
               end
               DST_SQ: begin
                  sq_in    = acc_ff;
                  e_in     = e_ff >> 1;
                  state_in = ST_POW;
               end
               DST_X: begin
                  res_in   = acc_ff;
                  k_in     = k_ff + CW'(1);
                  state_in = ST_SQLP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_TEST: begin
            k_in = '0;
            if (res_ff == W'(1)) begin
               liar_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               state_in = ST_SQLP;
            end
         end
         ST_SQLP: begin
            acc_in = '0;
            cnt_in = CW'(W - 1);
            priority if (k_ff == s_ff) begin
               state_in = ST_FIN;
            end else if (res_ff == nm1_ff) begin
               liar_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               mx_in    = res_ff;
               my_in    = res_ff;
               dst_in   = DST_X;
               state_in = ST_MDBL;
            end
         end
         ST_FIN: begin
            // wait for the output reg to free up
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_liar_in = liar_ff;
               rsp_err_in  = err_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      nm1_ff      <= nm1_in;
      a_ff        <= a_in;
      e_ff        <= e_in;
      res_ff      <= res_in;
      sq_ff       <= sq_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      s_ff        <= s_in;
      k_ff        <= k_in;
      dst_ff      <= dst_in;
      liar_ff     <= liar_in;
      err_ff      <= err_in;
      rsp_liar_ff <= rsp_liar_in;
      rsp_err_ff  <= rsp_err_in;
   end

`ifndef SYNTH
   // an error verdict never claims a liar
   a_err_not_liar: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.is_liar && rsp_chan.input_error))
      else $error("response word flags both liar and input error");

   // the accumulator stays reduced throughout a product
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MDBL || state_ff == ST_MADD) |-> (acc_ff < n_ff && mx_ff < n_ff))
      else $error("multiply operand not reduced mod n");

   // the squaring loop never runs past s
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQLP) |-> (k_ff <= s_ff))
      else $error("squaring count past s");

   // a taken request word leaves the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_CHK))
      else $error("sequencer did not start on accepted word");
`endif

endmodule

`default_nettype wire

// ===== dv/slc_round_checker.sv =====
// ----------------------------------------------------------------------------
// slc_round_checker: verdict predictor and comparator for the liar check
// Watches both channels, predicts one verdict word per accepted request
// word and compares each accepted response word against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_round_checker (
   input  wire  clock,
   input  wire  reset,
   slc_req_if   req_chan,
   slc_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      slc_pkg::field_type  modulus;
      slc_pkg::field_type  base;
      logic                is_liar;
      logic                input_error;
      int                  index;
   } round_type;

   round_type  verdict_q[$];
   int         fails = 0;
   int         outstanding = 0;
   int         req_count = 0;

   assign fail_count = fails;
   assign pending = outstanding;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fails++;
   endtask

   // x*y mod n at double width
   function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] n);
      logic [127:0] prod;
      prod = 128'(x) * 128'(y);
      return 64'(prod % 128'(n));
   endfunction

   // One strong probable prime round: n-1 = d*2^s, x = a^d, then s squarings.
   function automatic round_type round_verdict(input slc_pkg::field_type modulus,
                                               input slc_pkg::field_type base);
      logic [63:0]  mask;
      logic [63:0]  n;
      logic [63:0]  a;
      logic [63:0]  d;
      logic [63:0]  x;
      logic [63:0]  sq;
      int           s;
      round_type    r;
      mask = ~64'h0 >> (64 - slc_pkg::WIDTH);
      n = 64'(modulus) & mask;
      a = 64'(base) & mask;
      r.modulus = modulus;
      r.base = base;
      r.is_liar = 1'b0;
      r.input_error = 1'b0;
      r.index = 0;
      if (!n[0] || n < 3 || a < 2 || a >= n) begin
         r.input_error = 1'b1;
         return r;
      end
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      x = 1;
      sq = a;
      while (d != 0) begin
         if (d[0])
            x = mul_mod(x, sq, n);
         sq = mul_mod(sq, sq, n);
         d = d >> 1;
      end
      if (x == 1) begin
         r.is_liar = 1'b1;
      end else begin
         for (int k = 0; k < s; k++) begin
            if (x == n - 1) begin
               r.is_liar = 1'b1;
               break;
            end
            x = mul_mod(x, x, n);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      round_type want;
      round_type next;
      if (!reset) begin
         // response side first, so a same-edge request cannot match it
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("response word (is_liar %b, input_error %b) unexpected",
                                         rsp_chan.is_liar, rsp_chan.input_error));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_chan.is_liar !== want.is_liar)
                  report_mismatch($sformatf("word %0d n=%0d a=%0d: is_liar %b, predicted %b",
                                            want.index, want.modulus, want.base,
                                            rsp_chan.is_liar, want.is_liar));
               if (rsp_chan.input_error !== want.input_error)
                  report_mismatch($sformatf("word %0d n=%0d a=%0d: input_error %b, predicted %b",
                                            want.index, want.modulus, want.base,
                                            rsp_chan.input_error, want.input_error));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            next = round_verdict(req_chan.modulus, req_chan.base);
            next.index = req_count;
            req_count++;
            verdict_q.push_back(next);
         end
      end
      outstanding = verdict_q.size();
   end

endmodule

`default_nettype wire

// ===== dv/strong_liar_check_core_test.sv =====
// ----------------------------------------------------------------------------
// strong_liar_check_core_test: testbench top for the strong liar check
// Drives operand words with random gaps, stalls the response side, and
// leaves prediction and comparison to slc_round_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module strong_liar_check_core_test;

   localparam int RANDOM_WORDS = 160;
   // cycles with no word moving on either channel
   localparam int IDLE_LIMIT = 40000;
   // drain time after the last verdict
   localparam int TAIL_CYCLES = 60;

   logic  clock;
   logic  reset;
   int    fail_count;
   int    pending;
   int    idle_cycles = 0;
   logic  calm = 1'b0;          // no gaps and no stalls while set
   logic  req_taken = 1'b0;     // a request word moved at the last rising edge
   logic  rsp_taken = 1'b0;     // a response word moved at the last rising edge

   slc_req_if req_chan ();
   slc_rsp_if rsp_chan ();

   strong_liar_check_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   slc_round_checker round_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Handshake flags, sampled at the rising edge and read at the falling one.
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
      rsp_taken <= rsp_chan.valid && rsp_chan.ready;
   end

   // Watchdog: any long stretch with no word moving ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("strong_liar_check_core_test failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input slc_pkg::field_type n, input slc_pkg::field_type a);
      int gap;
      gap = calm ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.modulus <= n;
      req_chan.base <= a;
      do @(negedge clock); while (!req_taken);
   endtask

   // Hold off the sender until every predicted verdict has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Response side: per word, either ready stays up (always when calm) or ready
   // drops, the responder waits for valid and then stalls on it before raising ready.
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(6, 0);
         if (hold != 0) begin
            rsp_chan.ready <= 1'b0;
            @(negedge clock);
            while (!rsp_chan.valid) @(negedge clock);
            repeat (hold - 1) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(negedge clock); while (!rsp_taken);
      end
   end

   initial begin
      slc_pkg::field_type  n;
      slc_pkg::field_type  a;
      logic [63:0]         w;
      int                  bits;
      int                  kind;
      int                  f;
      logic                prime;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.modulus = '0;
      req_chan.base = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed words ----
      send_word(32'd0, 32'd0);                      // all zero: modulus too small
      send_word(32'd1, 32'd0);                      // modulus one
      send_word(32'd2, 32'hFFFF_FFFF);              // modulus two, even
      send_word(32'd3, 32'd2);                      // smallest legal round
      send_word(32'd3, 32'd3);                      // base equal to modulus
      send_word(32'd5, 32'd1);                      // base one
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);      // composite, base n-1 always lies
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);      // all ones, base equal to modulus
      send_word(32'hFFFF_FFFE, 32'd2);              // largest even modulus
      send_word(32'hFFFF_FFFB, 32'd2);              // largest 32-bit prime
      send_word(32'hFFFF_FFFB, 32'hFFFF_FFFA);      // prime, base n-1
      send_word(32'hFFFF_FFFB, 32'h5555_5555);      // prime, alternating base bits
      send_word(32'hFFFF_FFFB, 32'd0);              // base zero under a big modulus
      send_word(32'd2047, 32'd2);                   // strong pseudoprime to base 2
      send_word(32'd2047, 32'd3);                   // same modulus, base 3 witnesses
      send_word(32'd561, 32'd2);                    // absolute Fermat pseudoprime
      send_word(32'd25326001, 32'd5);               // pseudoprime to bases 2, 3, 5
      send_word(32'd3215031751, 32'd7);             // pseudoprime to bases 2, 3, 5, 7
      send_word(32'd9, 32'd2);                      // small odd composite
      send_word(32'd65537, 32'd3);                  // prime, 16 squarings
      send_word(32'h8000_0001, 32'h2AAA_AAAA);      // n-1 = 2^31: longest squaring chain
      send_word(32'd7, 32'hFFFF_FFFF);              // base far above modulus

      // pressure: nothing in flight before the random part starts
      drain_results();

      // ---- random words ----
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = ((i / 20) % 4) == 3;
         if (i == RANDOM_WORDS / 2)
            drain_results();
         kind = $urandom_range(99, 0);
         if (kind < 8) begin
            // raw noise, full-range bits on both fields
            n = $urandom;
            a = $urandom;
         end else if (kind < 20) begin
            // broken operands
            n = $urandom | 32'd1;
            case ($urandom_range(5, 0))
               0: a = 32'd0;
               1: a = 32'd1;
               2: a = n;
               3: a = $urandom_range(32'hFFFF_FFFF, n);
               4: begin
                  n = $urandom & ~32'd1;
                  a = $urandom;
               end
               default: begin
                  n = $urandom_range(2, 0);
                  a = $urandom_range(3, 0);
               end
            endcase
         end else if (kind < 28) begin
            // known strong pseudoprimes to base 2, mostly with base 2
            case ($urandom_range(7, 0))
               0: n = 32'd2047;
               1: n = 32'd3277;
               2: n = 32'd4033;
               3: n = 32'd4681;
               4: n = 32'd8321;
               5: n = 32'd15841;
               6: n = 32'd29341;
               default: n = 32'd42799;
            endcase
            a = ($urandom_range(3, 0) == 0) ? $urandom_range(n - 1, 2) : 32'd2;
         end else begin
            // well-formed round: odd modulus of random length, base in range
            bits = $urandom_range(32, 2);
            w = {32'h0, $urandom};
            w = (w & ((64'h1 << bits) - 1)) | (64'h1 << (bits - 1)) | 64'h1;
            n = w[31:0];
            // small moduli: often bump up to the next prime
            if (bits <= 20 && $urandom_range(2, 0) == 0) begin
               prime = 1'b0;
               while (!prime) begin
                  prime = 1'b1;
                  for (f = 3; f * f <= n; f += 2) begin
                     if (n % f == 0) begin
                        prime = 1'b0;
                        break;
                     end
                  end
                  if (!prime)
                     n = n + 2;
               end
            end
            a = ($urandom_range(7, 0) == 0) ? n - 1 : $urandom_range(n - 1, 2);
         end
         send_word(n, a);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("strong_liar_check_core_test passed");
      else
         $display("strong_liar_check_core_test failed");
      $finish;
   end

endmodule

`default_nettype wire
